@@ rtl/core/tasrp_pkg.sv @@
// Shared types and codes for the two-axis stepper ramp pulser.
`timescale 1ns / 1ps

package tasrp_pkg;

    localparam int REQ_W = 2;
    localparam int VAL_W = 16;
    localparam int POSN_W = 15;
    localparam int DLY_W = 7;
    localparam int TMR_W = 8;
    localparam int ERR_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ABS  = 2'd2;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_X_BOUNDS = 2'd1;
    localparam logic [ERR_W-1:0] ERR_Y_BOUNDS = 2'd2;
    localparam logic [ERR_W-1:0] ERR_BUSY     = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_X_EXTENT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_EXTENT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_LENGTH = 2'd3;

    // Configuration reset values.
    localparam logic [POSN_W-1:0] RST_X_EXTENT    = 15'd32767;
    localparam logic [POSN_W-1:0] RST_Y_EXTENT    = 15'd32767;
    localparam logic [DLY_W-1:0]  RST_BASE_DELAY  = 7'd7;
    localparam logic [DLY_W-1:0]  RST_RAMP_LENGTH = 7'd13;

    typedef struct packed {
        logic [POSN_W-1:0] x_extent;
        logic [POSN_W-1:0] y_extent;
        logic [DLY_W-1:0]  base_delay;
        logic [DLY_W-1:0]  ramp_length;
    } t_cfg;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic signed [VAL_W-1:0] x_value;
        logic signed [VAL_W-1:0] y_value;
    } t_req;

    typedef struct packed {
        logic              step_x;
        logic              step_y;
        logic              dir_x;
        logic              dir_y;
        logic              enable_x;
        logic              enable_y;
        logic              busy_res;
        logic [ERR_W-1:0]  error_code;
        logic [POSN_W-1:0] pos_x;
        logic [POSN_W-1:0] pos_y;
    } t_result;

endpackage

@@ rtl/core/tasrp_if.sv @@
// Handshake channel interfaces for requests, results and configuration writes.
`timescale 1ns / 1ps

interface tasrp_req_if;
    logic                                       valid;
    logic                                       ready;
    logic [tasrp_pkg::REQ_W-1:0]                req_type;
    logic signed [tasrp_pkg::VAL_W-1:0]         x_value;
    logic signed [tasrp_pkg::VAL_W-1:0]         y_value;

    modport source (output valid, req_type, x_value, y_value, input ready);
    modport sink (input valid, req_type, x_value, y_value, output ready);
endinterface

interface tasrp_res_if;
    logic                          valid;
    logic                          ready;
    logic                          step_x;
    logic                          step_y;
    logic                          dir_x;
    logic                          dir_y;
    logic                          enable_x;
    logic                          enable_y;
    logic                          busy_res;
    logic [tasrp_pkg::ERR_W-1:0]   error_code;
    logic [tasrp_pkg::POSN_W-1:0]  pos_x;
    logic [tasrp_pkg::POSN_W-1:0]  pos_y;

    modport source (output valid, step_x, step_y, dir_x, dir_y, enable_x, enable_y,
                    busy_res, error_code, pos_x, pos_y, input ready);
    modport sink (input valid, step_x, step_y, dir_x, dir_y, enable_x, enable_y,
                  busy_res, error_code, pos_x, pos_y, output ready);
endinterface

interface tasrp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tasrp_pkg::CFG_IDX_W-1:0]   index;
    logic [tasrp_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/tasrp_cfg_regs.sv @@
// Configuration register file: extents, cruise delay and ramp length.
`timescale 1ns / 1ps

module tasrp_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [tasrp_pkg::CFG_IDX_W-1:0] i_wr_idx,
    input  logic [tasrp_pkg::CFG_DATA_W-1:0] i_wr_data,
    output tasrp_pkg::t_cfg                 o_cfg
);

    tasrp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_extent    <= tasrp_pkg::RST_X_EXTENT;
            r_cfg.y_extent    <= tasrp_pkg::RST_Y_EXTENT;
            r_cfg.base_delay  <= tasrp_pkg::RST_BASE_DELAY;
            r_cfg.ramp_length <= tasrp_pkg::RST_RAMP_LENGTH;
        end else if (i_wr_en) begin
            case (i_wr_idx)
                tasrp_pkg::CFG_X_EXTENT: begin
                    r_cfg.x_extent <= i_wr_data;
                end
                tasrp_pkg::CFG_Y_EXTENT: begin
                    r_cfg.y_extent <= i_wr_data;
                end
                tasrp_pkg::CFG_BASE_DELAY: begin
                    r_cfg.base_delay <= i_wr_data[tasrp_pkg::DLY_W-1:0];
                end
                tasrp_pkg::CFG_RAMP_LENGTH: begin
                    r_cfg.ramp_length <= i_wr_data[tasrp_pkg::DLY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/tasrp_engine.sv @@
// Motion state and the per-item update for moves and ticks.
`timescale 1ns / 1ps

module tasrp_engine #(
    parameter int POS_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  tasrp_pkg::t_req      i_req,
    input  tasrp_pkg::t_cfg      i_cfg,
    output tasrp_pkg::t_result   o_res
);

    localparam int PW = tasrp_pkg::POSN_W;
    localparam int TW = tasrp_pkg::TMR_W;
    localparam int DW = tasrp_pkg::DLY_W;

    logic [PW-1:0]        r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic [1:0]           r_dir, n_dir;
    logic [POS_WIDTH-1:0] r_total_x, r_total_y, n_total_x, n_total_y;
    logic [POS_WIDTH-1:0] r_done_x, r_done_y, n_done_x, n_done_y;
    logic [TW-1:0]        r_timer, n_timer;
    logic                 r_pulse, n_pulse;
    logic                 r_axis, n_axis;
    logic                 r_moving, n_moving;

    logic signed [17:0]   tx, ty, dx, dy;
    logic [17:0]          adx, ady;
    logic                 x_oob, y_oob;
    logic                 x_left, y_left;
    logic                 load_hp;
    logic                 step_x, step_y;
    logic [tasrp_pkg::ERR_W-1:0] err;

    // Half-period of the step pulse for step k of an n-step run on one axis.
    function automatic logic [TW-1:0] half_period(
        input logic [POS_WIDTH-1:0] k,
        input logic [POS_WIDTH-1:0] n,
        input logic [DW-1:0]        base,
        input logic [DW-1:0]        ramp
    );
        logic [POS_WIDTH-1:0] rem;
        logic [TW-1:0]        d;
        rem = n - k;
        if (k < POS_WIDTH'(ramp)) begin
            d = TW'(base) + TW'(ramp) - TW'(k[DW-1:0]);
        end else if ((n > k) && (rem < POS_WIDTH'(ramp))) begin
            d = TW'(base) + TW'(rem[DW-1:0]);
        end else begin
            d = TW'(base);
        end
        if (d == '0) begin
            d = TW'(1);
        end
        return d;
    endfunction

    // Targets, bounds and step counts for a move.
    always_comb begin
        if (i_req.req_type == tasrp_pkg::REQ_REL) begin
            tx = $signed({3'b000, r_pos_x}) + $signed({{2{i_req.x_value[15]}}, i_req.x_value});
            ty = $signed({3'b000, r_pos_y}) + $signed({{2{i_req.y_value[15]}}, i_req.y_value});
        end else begin
            tx = $signed({{2{i_req.x_value[15]}}, i_req.x_value});
            ty = $signed({{2{i_req.y_value[15]}}, i_req.y_value});
        end
        x_oob = tx[17] || (tx > $signed({3'b000, i_cfg.x_extent}));
        y_oob = ty[17] || (ty > $signed({3'b000, i_cfg.y_extent}));
        dx    = tx - $signed({3'b000, r_pos_x});
        dy    = ty - $signed({3'b000, r_pos_y});
        adx   = dx[17] ? 18'(-dx) : 18'(dx);
        ady   = dy[17] ? 18'(-dy) : 18'(dy);
    end

    always_comb begin
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_dir     = r_dir;
        n_total_x = r_total_x;
        n_total_y = r_total_y;
        n_done_x  = r_done_x;
        n_done_y  = r_done_y;
        n_timer   = r_timer;
        n_pulse   = r_pulse;
        n_axis    = r_axis;
        n_moving  = r_moving;
        step_x    = 1'b0;
        step_y    = 1'b0;
        err       = tasrp_pkg::ERR_NONE;
        load_hp   = 1'b0;
        x_left    = r_done_x < r_total_x;
        y_left    = r_done_y < r_total_y;

        case (i_req.req_type)
            tasrp_pkg::REQ_REL, tasrp_pkg::REQ_ABS: begin
                if (r_moving) begin
                    err = tasrp_pkg::ERR_BUSY;
                end else if (x_oob) begin
                    err = tasrp_pkg::ERR_X_BOUNDS;
                end else if (y_oob) begin
                    err = tasrp_pkg::ERR_Y_BOUNDS;
                end else begin
                    // A zero offset leaves that axis's direction bit alone.
                    if (dx > 0) n_dir[0] = 1'b1;
                    if (dx < 0) n_dir[0] = 1'b0;
                    if (dy > 0) n_dir[1] = 1'b1;
                    if (dy < 0) n_dir[1] = 1'b0;
                    n_total_x = POS_WIDTH'(adx[15:0]);
                    n_total_y = POS_WIDTH'(ady[15:0]);
                    n_done_x  = '0;
                    n_done_y  = '0;
                    n_pos_x   = tx[PW-1:0];
                    n_pos_y   = ty[PW-1:0];
                    if ((n_total_x != '0) || (n_total_y != '0)) begin
                        n_moving = 1'b1;
                        n_axis   = (n_total_x == '0);
                        n_pulse  = 1'b1;
                        load_hp  = 1'b1;
                    end else begin
                        n_moving = 1'b0;
                        n_pulse  = 1'b0;
                        n_timer  = '0;
                    end
                end
            end
            tasrp_pkg::REQ_TICK: begin
                if (r_moving) begin
                    if (!x_left && !y_left) begin
                        n_moving = 1'b0;
                        n_pulse  = 1'b0;
                        n_timer  = '0;
                    end else begin
                        if (!n_axis && !x_left) n_axis = 1'b1;
                        if (n_axis && !y_left) n_axis = 1'b0;
                        step_x = !n_axis && r_pulse;
                        step_y = n_axis && r_pulse;
                        if (r_timer > TW'(1)) begin
                            n_timer = r_timer - TW'(1);
                        end else if (r_pulse) begin
                            n_pulse = 1'b0;
                            load_hp = 1'b1;
                        end else begin
                            // End of the low half: count the step, then switch axes
                            // if the other one still has steps.
                            if (!n_axis) n_done_x = r_done_x + POS_WIDTH'(1);
                            else n_done_y = r_done_y + POS_WIDTH'(1);
                            x_left = n_done_x < r_total_x;
                            y_left = n_done_y < r_total_y;
                            if (!n_axis && y_left) n_axis = 1'b1;
                            else if (n_axis && x_left) n_axis = 1'b0;
                            if (!x_left && !y_left) begin
                                n_moving = 1'b0;
                                n_timer  = '0;
                            end else begin
                                n_pulse = 1'b1;
                                load_hp = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (load_hp) begin
            n_timer = half_period(n_axis ? n_done_y : n_done_x,
                                  n_axis ? n_total_y : n_total_x,
                                  i_cfg.base_delay, i_cfg.ramp_length);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_dir     <= '0;
            r_total_x <= '0;
            r_total_y <= '0;
            r_done_x  <= '0;
            r_done_y  <= '0;
            r_timer   <= '0;
            r_pulse   <= 1'b0;
            r_axis    <= 1'b0;
            r_moving  <= 1'b0;
        end else if (i_fire) begin
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_dir     <= n_dir;
            r_total_x <= n_total_x;
            r_total_y <= n_total_y;
            r_done_x  <= n_done_x;
            r_done_y  <= n_done_y;
            r_timer   <= n_timer;
            r_pulse   <= n_pulse;
            r_axis    <= n_axis;
            r_moving  <= n_moving;
        end
    end

    always_comb begin
        o_res.step_x     = step_x;
        o_res.step_y     = step_y;
        o_res.dir_x      = n_dir[0];
        o_res.dir_y      = n_dir[1];
        o_res.enable_x   = n_moving && (n_done_x < n_total_x);
        o_res.enable_y   = n_moving && (n_done_y < n_total_y);
        o_res.busy_res   = n_moving;
        o_res.error_code = err;
        o_res.pos_x      = n_pos_x;
        o_res.pos_y      = n_pos_y;
    end

endmodule

@@ rtl/core/two_axis_stepper_ramp_pulser_top.sv @@
// Top level of the two-axis stepper ramp pulser: request stage, engine, result register.
`timescale 1ns / 1ps

// Two-axis step generator with a trapezoidal speed ramp. Each request (tick,
// relative move or absolute move) gives exactly one result. A request is
// registered on transfer, then processed by the motion engine once the result
// register is free or draining, and its result lands in that output register.
// One request is taken every cycle while the result side keeps up; the rate
// is set by the state update in the engine, which every request must pass
// through in order. Configuration writes are accepted every cycle and must
// only be issued while no request is in flight.
module two_axis_stepper_ramp_pulser_top #(
    parameter int POS_WIDTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tasrp_req_if.sink    i_req,
    tasrp_res_if.source  o_res,
    tasrp_cfg_if.sink    i_cfg
);

    tasrp_pkg::t_cfg    cfg;
    tasrp_pkg::t_req    r_req;
    tasrp_pkg::t_result eng_res;
    tasrp_pkg::t_result r_res;
    logic               r_in_valid;
    logic               r_out_valid;
    logic               fire;

    assign i_cfg.ready = 1'b1;

    tasrp_cfg_regs u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg.valid),
        .i_wr_idx  (i_cfg.index),
        .i_wr_data (i_cfg.data),
        .o_cfg     (cfg)
    );

    // The staged request is processed when the result register is free or drains.
    assign fire        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.req_type <= i_req.req_type;
            r_req.x_value  <= i_req.x_value;
            r_req.y_value  <= i_req.y_value;
        end
    end

    tasrp_engine #(
        .POS_WIDTH (POS_WIDTH)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_req),
        .i_cfg   (cfg),
        .o_res   (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= eng_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.step_x     = r_res.step_x;
    assign o_res.step_y     = r_res.step_y;
    assign o_res.dir_x      = r_res.dir_x;
    assign o_res.dir_y      = r_res.dir_y;
    assign o_res.enable_x   = r_res.enable_x;
    assign o_res.enable_y   = r_res.enable_y;
    assign o_res.busy_res   = r_res.busy_res;
    assign o_res.error_code = r_res.error_code;
    assign o_res.pos_x      = r_res.pos_x;
    assign o_res.pos_y      = r_res.pos_y;

    // Only one axis steps at a time.
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.step_x && r_res.step_y))
        else $error("both step pins high in one result");

    // A rejected move never produces a step pulse.
    a_err_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.error_code != tasrp_pkg::ERR_NONE))
            |-> (!r_res.step_x && !r_res.step_y))
        else $error("step pulse on a rejected move");

    // An enabled axis implies a running move.
    a_enable_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.enable_x || r_res.enable_y)) |-> r_res.busy_res)
        else $error("axis enabled while idle");

    // A staged request that is not processed stays staged.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_req)))
        else $error("staged request lost");

endmodule

@@ bench/two_axis_stepper_ramp_pulser_top_tb.sv @@
// Self-checking testbench for the two-axis stepper ramp pulser top level.
`timescale 1ns / 1ps

module two_axis_stepper_ramp_pulser_top_tb;

    localparam logic [tasrp_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam bit AXIS_X = 1'b0;
    localparam bit AXIS_Y = 1'b1;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TAIL_CYCLES = 10;
    localparam int NOISE_SPAN = 0;
    localparam int SWEEP_LEN = 20;

    typedef struct {
        tasrp_pkg::t_req    req;
        bit                 typed;
        bit                 drain;
        tasrp_pkg::t_result want;
    } t_row;

    typedef struct {
        int x_ext;
        int y_ext;
        int base;
        int ramp;
        int max_off;
        int quota;
    } t_phase;

    logic i_clk;
    logic i_rst_n;

    tasrp_req_if req_ch ();
    tasrp_res_if res_ch ();
    tasrp_cfg_if cfg_ch ();

    two_axis_stepper_ramp_pulser_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Mirror of the pulser state, advanced once per accepted request.
    tasrp_pkg::t_cfg cfg_m;
    logic [14:0] pos_x_m;
    logic [14:0] pos_y_m;
    logic [1:0]  dir_m;
    logic [15:0] tot_x;
    logic [15:0] tot_y;
    logic [15:0] cnt_x;
    logic [15:0] cnt_y;
    logic [7:0]  htimer;
    logic        pulse_m;
    logic        axis_m;
    logic        moving_m;

    tasrp_pkg::t_result results_due[$];
    t_row    directed_rows[$];
    t_phase  plan[6];

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  active_items = 0;
    int  moves_taken = 0;
    int  moves_refused = 0;
    int  settings_loaded = 0;
    int  quiet_cycles = 0;
    bit  fast_feed = 1'b0;
    bit  hold_off_req = 1'b0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [7:0] half_ticks(logic [15:0] k, logic [15:0] n);
        int kk = k;
        int nn = n;
        int b = cfg_m.base_delay;
        int rl = cfg_m.ramp_length;
        int d;
        if (kk < rl) begin
            d = b + rl - kk;
        end else if (nn > kk && nn - kk < rl) begin
            d = b + (nn - kk);
        end else begin
            d = b;
        end
        if (d == 0) begin
            d = 1;
        end
        return d[7:0];
    endfunction

    function automatic void set_reg(logic [tasrp_pkg::CFG_IDX_W-1:0] idx,
                                    logic [tasrp_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            tasrp_pkg::CFG_X_EXTENT:    cfg_m.x_extent = data[tasrp_pkg::POSN_W-1:0];
            tasrp_pkg::CFG_Y_EXTENT:    cfg_m.y_extent = data[tasrp_pkg::POSN_W-1:0];
            tasrp_pkg::CFG_BASE_DELAY:  cfg_m.base_delay = data[tasrp_pkg::DLY_W-1:0];
            tasrp_pkg::CFG_RAMP_LENGTH: cfg_m.ramp_length = data[tasrp_pkg::DLY_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic tasrp_pkg::t_result advance_pulser(tasrp_pkg::t_req r);
        tasrp_pkg::t_result res;
        int vx, vy, tx, ty, dx, dy;
        logic sx, sy, xl, yl;
        logic [tasrp_pkg::ERR_W-1:0] err;
        sx = 1'b0;
        sy = 1'b0;
        err = tasrp_pkg::ERR_NONE;
        if (r.req_type == tasrp_pkg::REQ_REL || r.req_type == tasrp_pkg::REQ_ABS) begin
            if (moving_m) begin
                err = tasrp_pkg::ERR_BUSY;
            end else begin
                vx = $signed(r.x_value);
                vy = $signed(r.y_value);
                tx = (r.req_type == tasrp_pkg::REQ_REL) ? int'(pos_x_m) + vx : vx;
                ty = (r.req_type == tasrp_pkg::REQ_REL) ? int'(pos_y_m) + vy : vy;
                if (tx < 0 || tx > int'(cfg_m.x_extent)) begin
                    err = tasrp_pkg::ERR_X_BOUNDS;
                end else if (ty < 0 || ty > int'(cfg_m.y_extent)) begin
                    err = tasrp_pkg::ERR_Y_BOUNDS;
                end else begin
                    dx = tx - int'(pos_x_m);
                    dy = ty - int'(pos_y_m);
                    // An axis with no offset keeps its previous direction.
                    if (dx > 0) dir_m[0] = 1'b1;
                    if (dx < 0) dir_m[0] = 1'b0;
                    if (dy > 0) dir_m[1] = 1'b1;
                    if (dy < 0) dir_m[1] = 1'b0;
                    tot_x = 16'(dx < 0 ? -dx : dx);
                    tot_y = 16'(dy < 0 ? -dy : dy);
                    cnt_x = '0;
                    cnt_y = '0;
                    pos_x_m = tx[14:0];
                    pos_y_m = ty[14:0];
                    if (tot_x != 0 || tot_y != 0) begin
                        moving_m = 1'b1;
                        axis_m = (tot_x != 0) ? AXIS_X : AXIS_Y;
                        pulse_m = 1'b1;
                        htimer = (axis_m == AXIS_Y) ? half_ticks('0, tot_y)
                                                    : half_ticks('0, tot_x);
                    end else begin
                        moving_m = 1'b0;
                        pulse_m = 1'b0;
                        htimer = '0;
                    end
                end
            end
        end else if (r.req_type == tasrp_pkg::REQ_TICK && moving_m) begin
            xl = cnt_x < tot_x;
            yl = cnt_y < tot_y;
            if (!xl && !yl) begin
                moving_m = 1'b0;
                pulse_m = 1'b0;
                htimer = '0;
            end else begin
                if (axis_m == AXIS_X && !xl) axis_m = AXIS_Y;
                if (axis_m == AXIS_Y && !yl) axis_m = AXIS_X;
                if (axis_m == AXIS_X) sx = pulse_m;
                else sy = pulse_m;
                if (htimer > 1) begin
                    htimer = htimer - 1'b1;
                end else if (pulse_m) begin
                    pulse_m = 1'b0;
                    htimer = (axis_m == AXIS_Y) ? half_ticks(cnt_y, tot_y)
                                                : half_ticks(cnt_x, tot_x);
                end else begin
                    // End of the low half: the step is complete.
                    if (axis_m == AXIS_X) cnt_x = cnt_x + 1'b1;
                    else cnt_y = cnt_y + 1'b1;
                    xl = cnt_x < tot_x;
                    yl = cnt_y < tot_y;
                    if (axis_m == AXIS_X && yl) axis_m = AXIS_Y;
                    else if (axis_m == AXIS_Y && xl) axis_m = AXIS_X;
                    if (!xl && !yl) begin
                        moving_m = 1'b0;
                        htimer = '0;
                    end else begin
                        pulse_m = 1'b1;
                        htimer = (axis_m == AXIS_Y) ? half_ticks(cnt_y, tot_y)
                                                    : half_ticks(cnt_x, tot_x);
                    end
                end
            end
        end
        res.step_x = sx;
        res.step_y = sy;
        res.dir_x = dir_m[0];
        res.dir_y = dir_m[1];
        res.enable_x = moving_m && (cnt_x < tot_x);
        res.enable_y = moving_m && (cnt_y < tot_y);
        res.busy_res = moving_m;
        res.error_code = err;
        res.pos_x = pos_x_m;
        res.pos_y = pos_y_m;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] result %0d: %s", $time, results_seen, msg);
        mismatch_count++;
    endtask

    task automatic compare_result(tasrp_pkg::t_result got, tasrp_pkg::t_result want);
        if (got.step_x !== want.step_x)
            report_mismatch($sformatf("step_x %0b, want %0b", got.step_x, want.step_x));
        if (got.step_y !== want.step_y)
            report_mismatch($sformatf("step_y %0b, want %0b", got.step_y, want.step_y));
        if (got.dir_x !== want.dir_x)
            report_mismatch($sformatf("dir_x %0b, want %0b", got.dir_x, want.dir_x));
        if (got.dir_y !== want.dir_y)
            report_mismatch($sformatf("dir_y %0b, want %0b", got.dir_y, want.dir_y));
        if (got.enable_x !== want.enable_x)
            report_mismatch($sformatf("enable_x %0b, want %0b", got.enable_x, want.enable_x));
        if (got.enable_y !== want.enable_y)
            report_mismatch($sformatf("enable_y %0b, want %0b", got.enable_y, want.enable_y));
        if (got.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res %0b, want %0b", got.busy_res, want.busy_res));
        if (got.error_code !== want.error_code)
            report_mismatch($sformatf("error_code %0d, want %0d", got.error_code,
                                      want.error_code));
        if (got.pos_x !== want.pos_x)
            report_mismatch($sformatf("pos_x %0d, want %0d", got.pos_x, want.pos_x));
        if (got.pos_y !== want.pos_y)
            report_mismatch($sformatf("pos_y %0d, want %0d", got.pos_y, want.pos_y));
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(tasrp_pkg::t_req r, bit typed, tasrp_pkg::t_result want);
        int g;
        tasrp_pkg::t_result res;
        bit active;
        g = fast_feed ? 0 : idle_len();
        if (g > 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= r.req_type;
        req_ch.x_value <= r.x_value;
        req_ch.y_value <= r.y_value;
        do @(posedge i_clk); while (!req_ch.ready);
        active = !(r.req_type == REQ_UNUSED ||
                   (r.req_type == tasrp_pkg::REQ_TICK && !moving_m));
        res = advance_pulser(r);
        results_due.push_back(typed ? want : res);
        items_sent++;
        if (active) active_items++;
        if (r.req_type == tasrp_pkg::REQ_REL || r.req_type == tasrp_pkg::REQ_ABS) begin
            if (res.error_code == tasrp_pkg::ERR_NONE) moves_taken++;
            else moves_refused++;
        end
    endtask

    task automatic send_tick();
        tasrp_pkg::t_req r;
        r.req_type = tasrp_pkg::REQ_TICK;
        r.x_value = 16'($urandom);
        r.y_value = 16'($urandom);
        send_item(r, 1'b0, '0);
    endtask

    task automatic pause_for_results();
        if (req_ch.valid) req_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_settings(t_phase ph);
        logic [tasrp_pkg::CFG_IDX_W-1:0] idx[4];
        logic [tasrp_pkg::CFG_DATA_W-1:0] val[4];
        idx = '{tasrp_pkg::CFG_X_EXTENT, tasrp_pkg::CFG_Y_EXTENT, tasrp_pkg::CFG_BASE_DELAY,
                tasrp_pkg::CFG_RAMP_LENGTH};
        val[0] = 15'(ph.x_ext);
        val[1] = 15'(ph.y_ext);
        // The delay registers only keep their low bits; fill the rest with junk.
        val[2] = {8'($urandom), 7'(ph.base)};
        val[3] = {8'($urandom), 7'(ph.ramp)};
        for (int i = 0; i < 4; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data <= val[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
            set_reg(idx[i], val[i]);
        end
        cfg_ch.valid <= 1'b0;
        settings_loaded++;
    endtask

    // Junk for the block: full-range values, near-boundary targets, unused codes.
    // Accepted moves that would take any steps become unused requests.
    task automatic send_noise();
        tasrp_pkg::t_req r;
        int tx, ty, span;
        r.req_type = 2'($urandom_range(0, 3));
        r.x_value = 16'($urandom);
        r.y_value = 16'($urandom);
        if ($urandom_range(0, 1) == 1) begin
            r.req_type = tasrp_pkg::REQ_ABS;
            r.x_value = 16'($urandom_range(0, 1) ? int'(cfg_m.x_extent) + $urandom_range(0, 1)
                                                 : -$signed($urandom_range(0, 1)));
            r.y_value = 16'($urandom_range(0, 1) ? int'(cfg_m.y_extent) + $urandom_range(0, 1)
                                                 : -$signed($urandom_range(0, 1)));
        end
        if ((r.req_type == tasrp_pkg::REQ_REL || r.req_type == tasrp_pkg::REQ_ABS) &&
            !moving_m) begin
            tx = $signed(r.x_value);
            ty = $signed(r.y_value);
            if (r.req_type == tasrp_pkg::REQ_REL) begin
                tx = tx + int'(pos_x_m);
                ty = ty + int'(pos_y_m);
            end
            span = (tx > int'(pos_x_m) ? tx - int'(pos_x_m) : int'(pos_x_m) - tx)
                 + (ty > int'(pos_y_m) ? ty - int'(pos_y_m) : int'(pos_y_m) - ty);
            if (tx >= 0 && tx <= int'(cfg_m.x_extent) && ty >= 0 &&
                ty <= int'(cfg_m.y_extent) && span > NOISE_SPAN) begin
                r.req_type = REQ_UNUSED;
            end
        end
        send_item(r, 1'b0, '0);
    endtask

    function automatic int pick_target(int p, int e, int m);
        int o, t;
        o = $urandom_range(0, 2 * m) - m;
        t = p + o;
        if (t < 0 || t > e) t = p - o;
        if (t < 0 || t > e) t = $urandom_range(0, e);
        return t;
    endfunction

    // A legal move followed by ticks until it completes, with some junk mixed in.
    task automatic run_move(int max_off);
        tasrp_pkg::t_req r;
        int tx, ty;
        tx = pick_target(int'(pos_x_m), int'(cfg_m.x_extent), max_off);
        ty = pick_target(int'(pos_y_m), int'(cfg_m.y_extent), max_off);
        if ($urandom_range(0, 1) == 1) begin
            r.req_type = tasrp_pkg::REQ_REL;
            r.x_value = 16'(tx - int'(pos_x_m));
            r.y_value = 16'(ty - int'(pos_y_m));
        end else begin
            r.req_type = tasrp_pkg::REQ_ABS;
            r.x_value = 16'(tx);
            r.y_value = 16'(ty);
        end
        send_item(r, 1'b0, '0);
        while (moving_m) begin
            if ($urandom_range(0, 19) == 0) send_noise();
            else send_tick();
        end
    endtask

    function automatic void add_row(logic [tasrp_pkg::REQ_W-1:0] rt, int x, int y, bit typed,
                                    bit drain, logic [tasrp_pkg::ERR_W-1:0] err);
        t_row row;
        row.req.req_type = rt;
        row.req.x_value = 16'(x);
        row.req.y_value = 16'(y);
        row.typed = typed;
        row.drain = drain;
        // Typed rows all sit at the reset state: idle, home position, directions low.
        row.want = '0;
        row.want.error_code = err;
        directed_rows.push_back(row);
    endfunction

    // Receiver: random ready with runs and gaps, plus one long forced hold-off.
    initial begin : receiver
        int run, g;
        res_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 8);
                repeat (run) @(posedge i_clk);
                g = idle_len();
                if (g > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        tasrp_pkg::t_result got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = {res_ch.step_x, res_ch.step_y, res_ch.dir_x, res_ch.dir_y,
                   res_ch.enable_x, res_ch.enable_y, res_ch.busy_res,
                   res_ch.error_code, res_ch.pos_x, res_ch.pos_y};
            if (results_due.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                compare_result(got, results_due.pop_front());
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("[%0t] no transfer for %0d cycles, %0d results outstanding", $time,
                     quiet_cycles, results_due.size());
            $display("two_axis_stepper_ramp_pulser_top_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int phase_end;
        t_phase sweep;
        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= tasrp_pkg::REQ_TICK;
        req_ch.x_value <= '0;
        req_ch.y_value <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= tasrp_pkg::CFG_X_EXTENT;
        cfg_ch.data <= '0;

        cfg_m.x_extent = tasrp_pkg::RST_X_EXTENT;
        cfg_m.y_extent = tasrp_pkg::RST_Y_EXTENT;
        cfg_m.base_delay = tasrp_pkg::RST_BASE_DELAY;
        cfg_m.ramp_length = tasrp_pkg::RST_RAMP_LENGTH;
        pos_x_m = '0;
        pos_y_m = '0;
        dir_m = '0;
        tot_x = '0;
        tot_y = '0;
        cnt_x = '0;
        cnt_y = '0;
        htimer = '0;
        pulse_m = 1'b0;
        axis_m = AXIS_X;
        moving_m = 1'b0;

        // Directed rows, all under the reset settings.
        add_row(tasrp_pkg::REQ_TICK, 0,      0,      1, 0, tasrp_pkg::ERR_NONE);
        add_row(REQ_UNUSED,          32767,  -32768, 1, 0, tasrp_pkg::ERR_NONE);
        add_row(tasrp_pkg::REQ_REL,  -1,     0,      1, 0, tasrp_pkg::ERR_X_BOUNDS);
        add_row(tasrp_pkg::REQ_ABS,  -32768, 0,      1, 0, tasrp_pkg::ERR_X_BOUNDS);
        add_row(tasrp_pkg::REQ_ABS,  32767,  -1,     1, 0, tasrp_pkg::ERR_Y_BOUNDS);
        add_row(tasrp_pkg::REQ_REL,  0,      -32768, 1, 0, tasrp_pkg::ERR_Y_BOUNDS);
        add_row(tasrp_pkg::REQ_ABS,  -1,     -1,     1, 0, tasrp_pkg::ERR_X_BOUNDS);
        add_row(tasrp_pkg::REQ_REL,  0,      0,      1, 0, tasrp_pkg::ERR_NONE);
        add_row(tasrp_pkg::REQ_ABS,  0,      0,      1, 0, tasrp_pkg::ERR_NONE);
        add_row(tasrp_pkg::REQ_REL,  2,      1,      0, 0, tasrp_pkg::ERR_NONE);
        add_row(tasrp_pkg::REQ_REL,  1,      1,      0, 0, tasrp_pkg::ERR_NONE);
        add_row(tasrp_pkg::REQ_ABS,  5,      5,      0, 0, tasrp_pkg::ERR_NONE);
        add_row(REQ_UNUSED,          0,      0,      0, 1, tasrp_pkg::ERR_NONE);
        add_row(tasrp_pkg::REQ_REL,  -1,     0,      0, 1, tasrp_pkg::ERR_NONE);
        add_row(tasrp_pkg::REQ_REL,  0,      -1,     0, 1, tasrp_pkg::ERR_NONE);
        add_row(tasrp_pkg::REQ_REL,  0,      1,      0, 1, tasrp_pkg::ERR_NONE);
        add_row(tasrp_pkg::REQ_TICK, -1,     -1,     0, 0, tasrp_pkg::ERR_NONE);

        plan[0] = '{40,    30,    1,   3,   4,  90};
        plan[1] = '{0,     25,    2,   1,   3,  80};
        plan[2] = '{20,    0,     0,   2,   4,  70};
        plan[3] = '{32767, 32767, 7,   13,  1,  60};
        plan[4] = '{32767, 32767, 127, 127, 0,  2};
        plan[5] = '{1000,  7,     3,   0,   4,  70};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
            if (directed_rows[i].drain) begin
                while (moving_m) send_tick();
            end
        end
        pause_for_results();

        // A short X run at the shortest pulse, out and back, fed back to back.
        sweep = '{32767, 32767, 0, 0, 0, 0};
        load_settings(sweep);
        fast_feed = 1'b1;
        add_row(tasrp_pkg::REQ_ABS, SWEEP_LEN, int'(pos_y_m), 0, 0, tasrp_pkg::ERR_NONE);
        add_row(tasrp_pkg::REQ_ABS, 0, int'(pos_y_m), 0, 0, tasrp_pkg::ERR_NONE);
        for (int i = directed_rows.size() - 2; i < directed_rows.size(); i++) begin
            send_item(directed_rows[i].req, 1'b0, '0);
            while (moving_m) send_tick();
        end
        fast_feed = 1'b0;
        pause_for_results();

        foreach (plan[p]) begin
            load_settings(plan[p]);
            // One long receiver hold-off while requests keep coming.
            if (p == 1) hold_off_req = 1'b1;
            phase_end = active_items + plan[p].quota;
            while (active_items < phase_end) begin
                if ($urandom_range(0, 99) < 70) run_move(plan[p].max_off);
                else send_noise();
                if ($urandom_range(0, 29) == 0) pause_for_results();
            end
            pause_for_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests (%0d moves taken, %0d refused), checked %0d results,",
                 items_sent, moves_taken, moves_refused, results_seen);
        $display("across %0d register settings including extent, delay and ramp extremes.",
                 settings_loaded);
        if (mismatch_count == 0) begin
            $display("two_axis_stepper_ramp_pulser_top_tb: PASS");
        end else begin
            $display("two_axis_stepper_ramp_pulser_top_tb: FAIL");
        end
        $finish;
    end

endmodule
